// ----- rtl/core/splittable_first_fit_packer_macros.svh -----
// Assertion helpers shared by the packer modules.
// Each use expects clk and arst_n in scope.
`ifndef SPLITTABLE_FIRST_FIT_PACKER_MACROS_SVH
`define SPLITTABLE_FIRST_FIT_PACKER_MACROS_SVH

// same-cycle implication
`define SPFF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPFF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/spff_pkg.sv -----
package spff_pkg;

	localparam int OPCODE_W = 2;
	localparam int RIDX_W   = 3;
	localparam int LIDX_W   = 2;
	localparam int AMT_W    = 16;
	localparam int PWR_W    = 16;
	localparam int ADDED_W  = 22;
	localparam int TOTAL_W  = 32;
	localparam int VIS_W    = 4;
	localparam int ACT_W    = 4;

	localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

	localparam int DEF_MAX_ROUTERS      = 8;
	localparam int DEF_LINKS_PER_ROUTER = 4;

	localparam logic [OPCODE_W-1:0] OP_LOAD_ROUTER = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOAD_LINK   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FLOW        = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NEXT,
		ST_RTR,
		ST_LINK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [AMT_W-1:0] spare;
		logic             in_use;
		logic [PWR_W-1:0] power;
	} entry_t;

	typedef struct packed {
		logic clr_step;
		logic start_flow;
		logic start_load;
		logic rtr_issue;
		logic rtr_step;
		logic link_step;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic walk_stop;
		logic rtr_empty;
		logic spread_end;
	} sts_t;

endpackage

// ----- rtl/core/spff_in_if.sv -----
interface spff_in_if;
	import spff_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [RIDX_W-1:0]   router_index;
	logic [LIDX_W-1:0]   link_index;
	logic [AMT_W-1:0]    amount;
	logic [PWR_W-1:0]    power_cost;

	modport source(output valid, opcode, router_index, link_index, amount, power_cost,
		input ready);
	modport sink(input valid, opcode, router_index, link_index, amount, power_cost,
		output ready);
endinterface

// ----- rtl/core/spff_out_if.sv -----
interface spff_out_if;
	import spff_pkg::*;

	logic               valid;
	logic               ready;
	logic [AMT_W-1:0]   forwarded_amount;
	logic [AMT_W-1:0]   lost_amount;
	logic [ADDED_W-1:0] power_added;
	logic [TOTAL_W-1:0] objective_total;
	logic [VIS_W-1:0]   routers_visited;

	modport source(output valid, forwarded_amount, lost_amount, power_added,
		objective_total, routers_visited, input ready);
	modport sink(input valid, forwarded_amount, lost_amount, power_added,
		objective_total, routers_visited, output ready);
endinterface

// ----- rtl/core/spff_ctrl.sv -----
`include "splittable_first_fit_packer_macros.svh"

module spff_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [spff_pkg::OPCODE_W-1:0] in_opcode,
	output logic                         out_valid,
	input  logic                         out_ready,
	output spff_pkg::cmd_t               cmd,
	input  spff_pkg::sts_t               sts
);
	import spff_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_xfer;

	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_xfer) state_d = (in_opcode == OP_FLOW) ? ST_NEXT : ST_DONE;
			end
			ST_NEXT: begin
				state_d = sts.walk_stop ? ST_DONE : ST_RTR;
			end
			ST_RTR: begin
				state_d = sts.rtr_empty ? ST_NEXT : ST_LINK;
			end
			ST_LINK: begin
				if (sts.spread_end) state_d = ST_NEXT;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_xfer) begin
					cmd.start_flow = (in_opcode == OP_FLOW);
					cmd.start_load = (in_opcode != OP_FLOW);
				end
			end
			ST_NEXT: cmd.rtr_issue = !sts.walk_stop;
			ST_RTR:  cmd.rtr_step  = 1'b1;
			ST_LINK: cmd.link_step = 1'b1;
			ST_DONE: cmd.capture   = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	`SPFF_ASSERT_NXT(a_flow_walks, in_xfer && in_opcode == OP_FLOW, state_q == ST_NEXT, "flow did not start its walk")
	`SPFF_ASSERT_NXT(a_capture_valid, cmd.capture, out_valid_q, "captured result not presented")
	`SPFF_ASSERT_IMP(a_link_order, state_q == ST_LINK, $past(state_q) == ST_RTR || $past(state_q) == ST_LINK, "link step without router step")

endmodule

// ----- rtl/core/spff_dpath.sv -----
`include "splittable_first_fit_packer_macros.svh"

module spff_dpath #(
	parameter int MAX_ROUTERS      = spff_pkg::DEF_MAX_ROUTERS,
	parameter int LINKS_PER_ROUTER = spff_pkg::DEF_LINKS_PER_ROUTER
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spff_pkg::ACT_W-1:0]    cfg_wdata,
	input  logic [spff_pkg::OPCODE_W-1:0] in_opcode,
	input  logic [spff_pkg::RIDX_W-1:0]   in_router_index,
	input  logic [spff_pkg::LIDX_W-1:0]   in_link_index,
	input  logic [spff_pkg::AMT_W-1:0]    in_amount,
	input  logic [spff_pkg::PWR_W-1:0]    in_power_cost,
	input  spff_pkg::cmd_t                cmd,
	output spff_pkg::sts_t                sts,
	output logic [spff_pkg::AMT_W-1:0]    forwarded_amount,
	output logic [spff_pkg::AMT_W-1:0]    lost_amount,
	output logic [spff_pkg::ADDED_W-1:0]  power_added,
	output logic [spff_pkg::TOTAL_W-1:0]  objective_total,
	output logic [spff_pkg::VIS_W-1:0]    routers_visited
);
	import spff_pkg::*;

	localparam int NLINKS = MAX_ROUTERS * LINKS_PER_ROUTER;
	localparam int RIW    = (MAX_ROUTERS > 1) ? $clog2(MAX_ROUTERS) : 1;
	localparam int RCW    = $clog2(MAX_ROUTERS + 1);
	localparam int LIW    = (LINKS_PER_ROUTER > 1) ? $clog2(LINKS_PER_ROUTER) : 1;
	localparam int KW     = (NLINKS > 1) ? $clog2(NLINKS) : 1;
	localparam int CW     = (RCW > ACT_W) ? RCW : ACT_W;

	entry_t rtr_mem_q [MAX_ROUTERS];
	entry_t lnk_mem_q [NLINKS];
	entry_t rtr_rd_q, lnk_rd_q;

	logic             rtr_we, rtr_re, lnk_we, lnk_re;
	logic [RIW-1:0]   rtr_wa, rtr_ra;
	logic [KW-1:0]    lnk_wa, lnk_ra;
	entry_t           rtr_wd, lnk_wd;

	logic [ACT_W-1:0]   act_q;
	logic [KW-1:0]      clr_q;
	logic [TOTAL_W-1:0] total_q;
	logic [ADDED_W-1:0] added_q;
	logic [AMT_W-1:0]   load_q, part_q, fwd_q;
	logic               partial_q;
	logic [VIS_W-1:0]   visited_q;
	logic [RCW-1:0]     r_q;
	logic [LIW-1:0]     l_q;

	logic [AMT_W-1:0]   fwd_out_q, lost_out_q;
	logic [ADDED_W-1:0] added_out_q;
	logic [TOTAL_W-1:0] total_out_q;
	logic [VIS_W-1:0]   visited_out_q;

	logic [CW-1:0]      n_eff;
	logic               clr_rtr;
	logic               rtr_full, rtr_empty;
	logic [AMT_W-1:0]   take;
	logic [AMT_W:0]     fwd_sum;
	logic [AMT_W-1:0]   fwd_nxt;
	logic               lnk_fit, lnk_empty;
	logic [AMT_W-1:0]   part_nxt;
	logic               spread_end;
	logic               chg_en;
	logic [PWR_W-1:0]   chg_p;
	logic [ADDED_W:0]   added_sum;
	logic [TOTAL_W:0]   total_sum;
	logic               ld_rtr_ok, ld_lnk_ok;

	assign n_eff = (CW'(act_q) > CW'(MAX_ROUTERS)) ? CW'(MAX_ROUTERS) : CW'(act_q);
	assign clr_rtr = ((KW + 1)'(clr_q) < (KW + 1)'(MAX_ROUTERS));

	// router step
	assign rtr_empty = (rtr_rd_q.spare == '0);
	assign rtr_full  = (load_q >= rtr_rd_q.spare);
	assign take      = rtr_full ? rtr_rd_q.spare : load_q;
	assign fwd_sum   = (AMT_W + 1)'(fwd_q) + (AMT_W + 1)'(take);
	assign fwd_nxt   = fwd_sum[AMT_W] ? '1 : fwd_sum[AMT_W-1:0];

	// link step: first fit of the remaining part
	assign lnk_empty  = (lnk_rd_q.spare == '0);
	assign lnk_fit    = (part_q >= lnk_rd_q.spare);
	assign part_nxt   = lnk_empty ? part_q : (lnk_fit ? part_q - lnk_rd_q.spare : '0);
	assign spread_end = (part_nxt == '0) || (l_q == LIW'(LINKS_PER_ROUTER - 1));

	// one saturating charge per cycle: router power or link power
	always_comb begin
		chg_en = 1'b0;
		chg_p  = rtr_rd_q.power;
		if (cmd.rtr_step) begin
			chg_en = !rtr_empty && !rtr_rd_q.in_use;
			chg_p  = rtr_rd_q.power;
		end else if (cmd.link_step) begin
			chg_en = !lnk_empty && !lnk_rd_q.in_use;
			chg_p  = lnk_rd_q.power;
		end
	end

	assign added_sum = (ADDED_W + 1)'(added_q) + (ADDED_W + 1)'(chg_p);
	assign total_sum = (TOTAL_W + 1)'(total_q) + (TOTAL_W + 1)'(chg_p);

	assign ld_rtr_ok = (in_opcode == OP_LOAD_ROUTER) && (int'(in_router_index) < MAX_ROUTERS);
	assign ld_lnk_ok = (in_opcode == OP_LOAD_LINK) && (int'(in_router_index) < MAX_ROUTERS)
		&& (int'(in_link_index) < LINKS_PER_ROUTER);

	always_comb begin
		rtr_we = 1'b0;
		rtr_wa = RIW'(clr_q);
		rtr_wd = '0;
		lnk_we = 1'b0;
		lnk_wa = clr_q;
		lnk_wd = '0;
		if (cmd.clr_step) begin
			rtr_we = clr_rtr;
			lnk_we = 1'b1;
		end else if (cmd.start_load) begin
			rtr_we = ld_rtr_ok;
			rtr_wa = RIW'(in_router_index);
			rtr_wd = '{spare: in_amount, in_use: 1'b0, power: in_power_cost};
			lnk_we = ld_lnk_ok;
			lnk_wa = KW'(int'(in_router_index) * LINKS_PER_ROUTER + int'(in_link_index));
			lnk_wd = '{spare: in_amount, in_use: 1'b0, power: in_power_cost};
		end else if (cmd.rtr_step) begin
			rtr_we = !rtr_empty;
			rtr_wa = r_q[RIW-1:0];
			rtr_wd = '{spare: rtr_full ? '0 : rtr_rd_q.spare - load_q, in_use: 1'b1,
				power: rtr_rd_q.power};
		end else if (cmd.link_step) begin
			lnk_we = !lnk_empty;
			lnk_wa = KW'(int'(r_q) * LINKS_PER_ROUTER + int'(l_q));
			lnk_wd = '{spare: lnk_fit ? '0 : lnk_rd_q.spare - part_q, in_use: 1'b1,
				power: lnk_rd_q.power};
		end
	end

	// prefetch link zero with the router; later links one per cycle
	assign rtr_re = cmd.rtr_issue;
	assign rtr_ra = r_q[RIW-1:0];
	assign lnk_re = cmd.rtr_issue || (cmd.link_step && !spread_end);
	assign lnk_ra = cmd.rtr_issue ? KW'(int'(r_q) * LINKS_PER_ROUTER)
		: KW'(int'(r_q) * LINKS_PER_ROUTER + int'(l_q) + 1);

	always_ff @(posedge clk) begin
		if (rtr_we) rtr_mem_q[rtr_wa] <= rtr_wd;
		if (rtr_re) rtr_rd_q <= rtr_mem_q[rtr_ra];
	end

	always_ff @(posedge clk) begin
		if (lnk_we) lnk_mem_q[lnk_wa] <= lnk_wd;
		if (lnk_re) lnk_rd_q <= lnk_mem_q[lnk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= ACT_RESET;
			clr_q   <= '0;
			total_q <= '0;
		end else begin
			if (cfg_we) act_q <= cfg_wdata;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (chg_en) total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (chg_en) added_q <= added_sum[ADDED_W] ? '1 : added_sum[ADDED_W-1:0];
		if (cmd.start_flow || cmd.start_load) begin
			load_q    <= cmd.start_flow ? in_amount : '0;
			fwd_q     <= '0;
			added_q   <= '0;
			visited_q <= '0;
			r_q       <= '0;
			l_q       <= '0;
		end
		if (cmd.rtr_issue) visited_q <= visited_q + 1'b1;
		if (cmd.rtr_step) begin
			if (rtr_empty) begin
				r_q <= r_q + 1'b1;
			end else begin
				if (rtr_full) load_q <= load_q - rtr_rd_q.spare;
				part_q    <= take;
				partial_q <= !rtr_full;
				fwd_q     <= fwd_nxt;
				l_q       <= '0;
			end
		end
		if (cmd.link_step) begin
			part_q <= part_nxt;
			if (spread_end) begin
				// partial take: the load drops only by what the links absorbed
				if (partial_q) load_q <= part_nxt;
				r_q <= r_q + 1'b1;
				l_q <= '0;
			end else begin
				l_q <= l_q + 1'b1;
			end
		end
		if (cmd.capture) begin
			fwd_out_q     <= fwd_q;
			lost_out_q    <= load_q;
			added_out_q   <= added_q;
			total_out_q   <= total_q;
			visited_out_q <= visited_q;
		end
	end

	assign sts.clr_last   = (clr_q == KW'(NLINKS - 1));
	assign sts.walk_stop  = (load_q == '0) || (CW'(r_q) >= n_eff);
	assign sts.rtr_empty  = rtr_empty;
	assign sts.spread_end = spread_end;

	assign forwarded_amount = fwd_out_q;
	assign lost_amount      = lost_out_q;
	assign power_added      = added_out_q;
	assign objective_total  = total_out_q;
	assign routers_visited  = visited_out_q;

	`SPFF_ASSERT_IMP(a_issue_in_range, cmd.rtr_issue, CW'(r_q) < n_eff, "router read past active range")
	`SPFF_ASSERT_IMP(a_spread_nonzero, cmd.link_step, part_q != '0, "link step with nothing to spread")

endmodule

// ----- rtl/core/splittable_first_fit_packer.sv -----
// channel   modport  transfer moves
// in_ch     sink     opcode, router_index, link_index, amount, power_cost
// out_ch    source   forwarded_amount, lost_amount, power_added, objective_total,
//                    routers_visited
// cfg       write    active_routers (cfg_we, cfg_wdata)
//
// A load writes its table entry at the input transfer, then waits in DONE
// until its result can be captured. A flow passes NEXT and RTR for each router
// reached and LINK for each link visited (the router and link memories each
// give one registered read per cycle), then captures its result in DONE.
// After reset a clearing pass over all MAX_ROUTERS * LINKS_PER_ROUTER link entries
// zeroes both memories; in_ch.ready stays low until it ends.
// One item at a time; the next is accepted while a result waits in out_ch.
module splittable_first_fit_packer #(
	parameter int MAX_ROUTERS      = spff_pkg::DEF_MAX_ROUTERS,
	parameter int LINKS_PER_ROUTER = spff_pkg::DEF_LINKS_PER_ROUTER
) (
	input  logic                       clk,
	input  logic                       arst_n,
	spff_in_if.sink                    in_ch,
	spff_out_if.source                 out_ch,
	input  logic                       cfg_we,
	input  logic [spff_pkg::ACT_W-1:0] cfg_wdata
);
	import spff_pkg::*;

	cmd_t cmd;
	sts_t sts;

	spff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_opcode (in_ch.opcode),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	spff_dpath #(
		.MAX_ROUTERS      (MAX_ROUTERS),
		.LINKS_PER_ROUTER (LINKS_PER_ROUTER)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_opcode        (in_ch.opcode),
		.in_router_index  (in_ch.router_index),
		.in_link_index    (in_ch.link_index),
		.in_amount        (in_ch.amount),
		.in_power_cost    (in_ch.power_cost),
		.cmd              (cmd),
		.sts              (sts),
		.forwarded_amount (out_ch.forwarded_amount),
		.lost_amount      (out_ch.lost_amount),
		.power_added      (out_ch.power_added),
		.objective_total  (out_ch.objective_total),
		.routers_visited  (out_ch.routers_visited)
	);

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
	import spff_pkg::*;

	localparam int NR = DEF_MAX_ROUTERS;
	localparam int NL = DEF_LINKS_PER_ROUTER;
	localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;
	localparam int unsigned AMT_MAX = (1 << AMT_W) - 1;
	localparam int unsigned ADDED_MAX = (1 << ADDED_W) - 1;
	localparam realtime CLK_PERIOD = 12ns;
	localparam longint LIMIT_CYCLES = 2_000_000;
	localparam int DRAIN_CYCLES = 60;
	localparam int FINAL_WAIT = 20_000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [RIDX_W-1:0]   router_index;
		logic [LIDX_W-1:0]   link_index;
		logic [AMT_W-1:0]    amount;
		logic [PWR_W-1:0]    power_cost;
	} flow_cmd_t;

	typedef struct packed {
		logic [AMT_W-1:0]   forwarded;
		logic [AMT_W-1:0]   lost;
		logic [ADDED_W-1:0] added;
		logic [TOTAL_W-1:0] total;
		logic [VIS_W-1:0]   visited;
	} placement_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [ACT_W-1:0]    cfg_wdata;

	spff_in_if  in_ch();
	spff_out_if out_ch();

	splittable_first_fit_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// placement model state
	logic [AMT_W-1:0]   rtr_spare [NR]    = '{default: '0};
	bit                 rtr_used  [NR]    = '{default: 1'b0};
	logic [PWR_W-1:0]   rtr_pwr   [NR]    = '{default: '0};
	logic [AMT_W-1:0]   link_spare[NR*NL] = '{default: '0};
	bit                 link_used [NR*NL] = '{default: 1'b0};
	logic [PWR_W-1:0]   link_pwr  [NR*NL] = '{default: '0};
	logic [TOTAL_W-1:0] total_pwr = '0;
	logic [ACT_W-1:0]   act_routers = ACT_RESET;
	int unsigned        added_acc;

	flow_cmd_t  pending_cmds[$];
	placement_t placements_due[$];

	int  errors = 0;
	int  results_checked = 0;
	int  loads_seen = 0;
	int  flows_seen = 0;
	int  ignored_seen = 0;
	int  settings_seen = 1;
	bit  in_took = 1'b0;
	bit  sender_steady = 1'b0;
	bit  receiver_steady = 1'b0;
	bit  hold_req = 1'b0;
	bit  hold_served = 1'b0;
	int  gap_left = 0;
	int  burst_left = 0;
	int  rx_mode = 0;
	int  rx_mode_left = 0;
	int  rx_phase = 0;
	int  hold_left = 0;

	function automatic void charge_power(logic [PWR_W-1:0] p);
		longint unsigned t;
		added_acc = added_acc + p;
		if (added_acc > ADDED_MAX) added_acc = ADDED_MAX;
		t = longint'(total_pwr) + p;
		total_pwr = (t > 64'hFFFF_FFFF) ? '1 : t[TOTAL_W-1:0];
	endfunction

	// first fit over the links of router r, returns what the links could not take
	function automatic int unsigned fill_links(int r, int unsigned ld);
		int k;
		int unsigned sp;
		for (int l = 0; l < NL; l++) begin
			k = r * NL + l;
			sp = link_spare[k];
			if (sp > 0) begin
				if (!link_used[k]) begin
					link_used[k] = 1'b1;
					charge_power(link_pwr[k]);
				end
				if (ld >= sp) begin
					ld -= sp;
					link_spare[k] = '0;
				end else begin
					link_spare[k] = AMT_W'(sp - ld);
					ld = 0;
				end
			end
			if (ld == 0) break;
		end
		return ld;
	endfunction

	function automatic placement_t place_cmd(flow_cmd_t c);
		placement_t res;
		int unsigned load;
		int unsigned fwd;
		int unsigned sp;
		int unsigned n;
		int k;
		res = '0;
		added_acc = 0;
		fwd = 0;
		case (c.opcode)
			OP_LOAD_ROUTER: begin
				rtr_spare[c.router_index] = c.amount;
				rtr_pwr[c.router_index] = c.power_cost;
				rtr_used[c.router_index] = 1'b0;
			end
			OP_LOAD_LINK: begin
				k = c.router_index * NL + c.link_index;
				link_spare[k] = c.amount;
				link_pwr[k] = c.power_cost;
				link_used[k] = 1'b0;
			end
			OP_FLOW: begin
				load = c.amount;
				n = (act_routers > NR) ? NR : act_routers;
				for (int r = 0; r < NR; r++) begin
					if (r >= n || load == 0) break;
					res.visited++;
					sp = rtr_spare[r];
					if (sp == 0) continue;
					if (!rtr_used[r]) begin
						rtr_used[r] = 1'b1;
						charge_power(rtr_pwr[r]);
					end
					if (load >= sp) begin
						load -= sp;
						rtr_spare[r] = '0;
						fwd += sp;
						void'(fill_links(r, sp));
					end else begin
						rtr_spare[r] = AMT_W'(sp - load);
						fwd += load;
						// partial case: only what the links absorb leaves the flow
						load = fill_links(r, load);
					end
					if (fwd > AMT_MAX) fwd = AMT_MAX;
				end
				res.lost = AMT_W'(load);
			end
			default: ;
		endcase
		res.forwarded = AMT_W'(fwd);
		res.added = ADDED_W'(added_acc);
		res.total = total_pwr;
		return res;
	endfunction

	function automatic void queue_cmd(logic [OPCODE_W-1:0] op, int ri, int li,
		logic [AMT_W-1:0] amt, logic [PWR_W-1:0] pw);
		flow_cmd_t c;
		c.opcode = op;
		c.router_index = RIDX_W'(ri);
		c.link_index = LIDX_W'(li);
		c.amount = amt;
		c.power_cost = pw;
		pending_cmds.push_back(c);
	endfunction

	function automatic logic [AMT_W-1:0] pick_amount(int unsigned typical_max);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return AMT_W'($urandom);
			default: return AMT_W'($urandom_range(1, typical_max));
		endcase
	endfunction

	function automatic logic [PWR_W-1:0] pick_power();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PWR_W'($urandom);
		endcase
	endfunction

	// reload part of the table, then a run of flows with some noise mixed in
	function automatic void queue_round(int n_flows);
		for (int r = 0; r < NR; r++)
			if ($urandom_range(0, 4) != 0)
				queue_cmd(OP_LOAD_ROUTER, r, $urandom_range(0, NL - 1), pick_amount(300),
					pick_power());
		for (int k = 0; k < NR * NL; k++)
			if ($urandom_range(0, 4) != 0)
				queue_cmd(OP_LOAD_LINK, k / NL, k % NL, pick_amount(120), pick_power());
		for (int f = 0; f < n_flows; f++) begin
			case ($urandom_range(0, 11))
				0: queue_cmd(OP_IGNORED, $urandom, $urandom, AMT_W'($urandom), PWR_W'($urandom));
				1: queue_cmd(OP_LOAD_ROUTER, $urandom, $urandom, pick_amount(300), pick_power());
				2: queue_cmd(OP_LOAD_LINK, $urandom, $urandom, pick_amount(120), pick_power());
				default: ;
			endcase
			queue_cmd(OP_FLOW, $urandom, $urandom, pick_amount(1500), PWR_W'($urandom));
		end
	endfunction

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || placements_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_active(logic [ACT_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		act_routers = v;
		settings_seen++;
	endtask

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("[splittable_first_fit_packer] ERROR");
		$finish;
	end

	// record each input transfer and predict its result
	always @(posedge clk) begin : in_accept
		flow_cmd_t c;
		in_took = 1'b0;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			c = pending_cmds.pop_front();
			placements_due.push_back(place_cmd(c));
			in_took = 1'b1;
			case (c.opcode)
				OP_FLOW: flows_seen++;
				OP_IGNORED: ignored_seen++;
				default: loads_seen++;
			endcase
		end
	end

	always @(negedge clk) begin : in_drive
		logic nv;
		nv = 1'b0;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (in_ch.valid && !in_took) begin
			// hold until the transfer happens
			nv = 1'b1;
		end else begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if (!sender_steady && $urandom_range(0, 2) != 0)
					gap_left = $urandom_range(1, 12);
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_cmds.size() != 0) begin
				nv = 1'b1;
				burst_left--;
				in_ch.opcode <= pending_cmds[0].opcode;
				in_ch.router_index <= pending_cmds[0].router_index;
				in_ch.link_index <= pending_cmds[0].link_index;
				in_ch.amount <= pending_cmds[0].amount;
				in_ch.power_cost <= pending_cmds[0].power_cost;
			end
		end
		in_ch.valid <= nv;
	end

	always @(negedge clk) begin : out_drive
		logic nr;
		nr = 1'b1;
		if (hold_req && !hold_served) begin
			hold_left = HOLD_CYCLES;
			hold_served = 1'b1;
		end
		rx_phase++;
		if (hold_left > 0) begin
			hold_left--;
			nr = 1'b0;
		end else if (!receiver_steady) begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(20, 120);
			end
			rx_mode_left--;
			case (rx_mode)
				0: nr = 1'b1;
				1: nr = $urandom_range(0, 1);
				2: nr = ($urandom_range(0, 7) != 0);
				default: nr = (rx_phase % 8 < 3);
			endcase
		end
		out_ch.ready <= nr;
	end

	always @(posedge clk) begin : out_check
		placement_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (placements_due.size() == 0) begin
				errors++;
				$display("%0t: result transfer with nothing expected, actual %0d/%0d/%0d/%0d/%0d",
					$time, out_ch.forwarded_amount, out_ch.lost_amount, out_ch.power_added,
					out_ch.objective_total, out_ch.routers_visited);
			end else begin
				want = placements_due.pop_front();
				results_checked++;
				compare_field("forwarded_amount", want.forwarded, out_ch.forwarded_amount);
				compare_field("lost_amount", want.lost, out_ch.lost_amount);
				compare_field("power_added", want.added, out_ch.power_added);
				compare_field("objective_total", want.total, out_ch.objective_total);
				compare_field("routers_visited", want.visited, out_ch.routers_visited);
			end
		end
	end

	initial begin : main_seq
		static logic [ACT_W-1:0] act_plan [10] = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd8, 4'd2, 4'd9,
			4'd6, 4'd3, 4'd7};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.router_index = '0;
		in_ch.link_index = '0;
		in_ch.amount = '0;
		in_ch.power_cost = '0;
		out_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, zero flow, unused opcode, sum saturation, extremes
		queue_cmd(OP_FLOW, 0, 0, 16'd100, 16'd0);
		queue_cmd(OP_FLOW, 7, 3, 16'd0, 16'hFFFF);
		queue_cmd(OP_IGNORED, 7, 3, 16'hFFFF, 16'hFFFF);
		queue_cmd(OP_LOAD_ROUTER, 0, 0, 16'd60000, 16'hFFFF);
		queue_cmd(OP_LOAD_ROUTER, 1, 3, 16'd60000, 16'h8000);
		queue_cmd(OP_FLOW, 0, 0, 16'd50000, 16'd0);
		queue_cmd(OP_LOAD_LINK, 2, 0, 16'hFFFF, 16'hFFFF);
		queue_cmd(OP_LOAD_LINK, 2, 3, 16'd1, 16'd1);
		queue_cmd(OP_LOAD_ROUTER, 2, 0, 16'hFFFF, 16'd1);
		queue_cmd(OP_FLOW, 0, 0, 16'hFFFF, 16'd0);
		queue_cmd(OP_LOAD_LINK, 7, 3, 16'd5, 16'd3);
		queue_cmd(OP_LOAD_LINK, 7, 0, 16'd0, 16'hFFFF);
		queue_cmd(OP_LOAD_ROUTER, 7, 0, 16'd9, 16'd2);
		queue_cmd(OP_FLOW, 0, 0, 16'hFFFF, 16'd0);
		queue_cmd(OP_LOAD_ROUTER, 3, 0, 16'hFFFF, 16'd0);
		queue_cmd(OP_LOAD_ROUTER, 0, 0, 16'd0, 16'hFFFF);
		queue_cmd(OP_FLOW, 0, 0, 16'd1, 16'd0);
		queue_cmd(OP_LOAD_ROUTER, 1, 0, 16'd10, 16'd5);
		queue_cmd(OP_FLOW, 0, 0, 16'd20000, 16'd0);
		wait_idle();

		queue_round($urandom_range(6, 12));
		wait_idle();
		foreach (act_plan[p]) begin
			set_active(act_plan[p]);
			sender_steady = (p == 4 || p == 7);
			receiver_steady = (p == 7);
			// fill the block while the result side holds off
			if (p == 4) hold_req = 1'b1;
			queue_round($urandom_range(6, 12));
			if (p % 3 == 0) queue_round($urandom_range(6, 12));
			wait_idle();
		end

		// finish on the full router range with a last reload and flow
		sender_steady = 1'b1;
		receiver_steady = 1'b1;
		set_active(4'd8);
		queue_cmd(OP_LOAD_ROUTER, 5, 0, 16'd7, 16'hFFFF);
		queue_cmd(OP_FLOW, 0, 0, 16'd100, 16'd0);

		repeat (FINAL_WAIT) begin
			if (pending_cmds.size() == 0 && placements_due.size() == 0) break;
			@(posedge clk);
		end
		if (pending_cmds.size() != 0 || placements_due.size() != 0) begin
			errors++;
			$display("%0t: %0d items unsent, %0d results never arrived", $time,
				pending_cmds.size(), placements_due.size());
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d flows, %0d table loads, %0d unused-opcode items, %0d results",
			flows_seen, loads_seen, ignored_seen, results_checked);
		$display("over %0d router-count settings; final power total %0d",
			settings_seen, total_pwr);
		if (errors == 0)
			$display("[splittable_first_fit_packer] OK");
		else
			$display("[splittable_first_fit_packer] ERROR");
		$finish;
	end

endmodule

// ----- splittable_first_fit_packer.f -----
+incdir+rtl/core
rtl/core/spff_pkg.sv
rtl/core/spff_in_if.sv
rtl/core/spff_out_if.sv
rtl/core/spff_ctrl.sv
rtl/core/spff_dpath.sv
rtl/core/splittable_first_fit_packer.sv
verif/tb_top.sv
